/* sv/clat_pkg.sv */
// Shared types and constants for the clamped table-lookup arctangent unit.
// Used by every module of the unit; depends on nothing.
package clat_pkg;

    // Table geometry
    localparam int SAMPLES = 256;
    localparam int ADDR_W  = $clog2(SAMPLES + 1);

    // Field widths
    localparam int X_W     = 24;
    localparam int V_W     = 18;
    localparam int STEP_W  = 24;
    localparam int EIDX_W  = 9;
    localparam int FRAC_W  = 16;
    localparam int POS_W   = X_W + STEP_W;
    localparam int PIDX_W  = POS_W - 2 * FRAC_W;
    localparam int DIFF_W  = V_W + 1;
    localparam int PROD_W  = DIFF_W + FRAC_W + 1;

    // Stream packing
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 24;
    localparam int EIDX_LSB   = 0;
    localparam int EVAL_LSB   = EIDX_LSB + EIDX_W;
    localparam int X_LSB      = EVAL_LSB + V_W;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic signed [X_W-1:0] LOWER_RESET = -24'sd3276800;
    localparam logic signed [X_W-1:0] UPPER_RESET = 24'sd3276800;
    localparam logic [STEP_W-1:0]     STEP_RESET  = 24'd167117;

    // Queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOWER_LIMIT  = 2'd0,
        REG_UPPER_LIMIT  = 2'd1,
        REG_STEP_INVERSE = 2'd2
    } t_cfg_reg;

    typedef enum logic {
        MODE_LOAD = 1'b0,
        MODE_EVAL = 1'b1
    } t_mode;

    // One classified item as it travels from front to back
    typedef struct packed {
        t_mode                    mode;
        logic                     last;
        logic [X_W-1:0]           offset;
        logic [EIDX_W-1:0]        eidx;
        logic signed [V_W-1:0]    evalue;
    } t_work;

endpackage

/* sv/clat_front.sv */
// Front end: accepts stream items, clamps the argument and forms the table offset.
// Depends on clat_pkg.
module clat_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [clat_pkg::IN_DATA_W-1:0] i_s_tdata,
    input  logic                           i_s_tuser,
    input  logic                           i_s_tlast,
    input  logic signed [clat_pkg::X_W-1:0] i_lower,
    input  logic signed [clat_pkg::X_W-1:0] i_upper,
    output logic                           o_push_valid,
    input  logic                           i_push_ready,
    output clat_pkg::t_work                o_push_work
);
    import clat_pkg::*;

    logic                  r_valid;
    t_work                 r_work;
    t_work                 n_work;
    logic                  accept;
    logic signed [X_W-1:0] x_in;
    logic signed [X_W-1:0] x_floor;
    logic signed [X_W-1:0] x_clamp;
    logic signed [X_W:0]   diff;

    assign o_s_tready   = !r_valid || i_push_ready;
    assign accept       = i_s_tvalid && o_s_tready;
    assign o_push_valid = r_valid;
    assign o_push_work  = r_work;

    // Clamp floor first, then ceiling, and saturate a negative offset to zero
    always_comb begin
        x_in    = signed'(i_s_tdata[X_LSB +: X_W]);
        x_floor = (x_in < i_lower) ? i_lower : x_in;
        x_clamp = (x_floor > i_upper) ? i_upper : x_floor;
        diff    = {x_clamp[X_W-1], x_clamp} - {i_lower[X_W-1], i_lower};
        n_work.mode   = t_mode'(i_s_tuser);
        n_work.last   = i_s_tlast;
        n_work.offset = diff[X_W] ? '0 : diff[X_W-1:0];
        n_work.eidx   = i_s_tdata[EIDX_LSB +: EIDX_W];
        n_work.evalue = signed'(i_s_tdata[EVAL_LSB +: V_W]);
    end

    // Hold the item until the queue takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_push_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_work <= n_work;
        end
    end

endmodule

/* sv/clat_queue.sv */
// Short item queue that decouples the front end from the back end.
// Depends on clat_pkg.
module clat_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    output logic            o_push_ready,
    input  clat_pkg::t_work i_push_work,
    output logic            o_pop_valid,
    input  logic            i_pop_ready,
    output clat_pkg::t_work o_pop_work
);
    import clat_pkg::*;

    t_work             r_slot [0:QDEPTH-1];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              push;
    logic              pop;

    assign o_push_ready = (r_count != QCNT_W'(QDEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_work   = r_slot[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= i_push_work;
        end
    end

endmodule

/* sv/clat_back.sv */
// Back end: scales the offset, reads and writes the sample table, interpolates.
// Depends on clat_pkg.
module clat_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [clat_pkg::STEP_W-1:0]      i_step,
    input  logic                             i_pop_valid,
    output logic                             o_pop_ready,
    input  clat_pkg::t_work                  i_pop_work,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [clat_pkg::OUT_DATA_W-1:0]  o_m_tdata,
    output logic                             o_m_tlast
);
    import clat_pkg::*;

    logic                     en;

    // Stage 1: item taken from the queue
    logic                     r_s1_valid;
    t_work                    r_s1_work;

    // Stage 2: scaled position
    logic                     r_s2_valid;
    t_mode                    r_s2_mode;
    logic                     r_s2_last;
    logic [POS_W-1:0]         r_s2_pos;
    logic [EIDX_W-1:0]        r_s2_eidx;
    logic signed [V_W-1:0]    r_s2_evalue;

    // Stage 3: table samples and fraction
    logic                     r_s3_valid;
    logic                     r_s3_last;
    logic signed [V_W-1:0]    r_s3_a;
    logic signed [V_W-1:0]    r_s3_b;
    logic [FRAC_W-1:0]        r_s3_frac;

    // Stage 4: interpolation product
    logic                     r_s4_valid;
    logic                     r_s4_last;
    logic signed [V_W-1:0]    r_s4_a;
    logic signed [PROD_W-1:0] r_s4_prod;

    // Output register
    logic                     r_o_valid;
    logic                     r_o_last;
    logic [V_W-1:0]           r_o_value;

    logic signed [V_W-1:0]    table_mem [0:SAMPLES];

    logic [PIDX_W-1:0]        pos_idx;
    logic                     pos_sat;
    logic [ADDR_W-1:0]        rd_addr;
    logic [FRAC_W-1:0]        frac;
    logic                     do_write;
    logic                     do_read;
    logic signed [DIFF_W-1:0] diff;
    logic [V_W-1:0]           n_value;

    // Whole back pipeline moves when the output slot is free or being taken
    assign en          = !r_o_valid || i_m_tready;
    assign o_pop_ready = en;

    // Saturate the index at the last interval
    always_comb begin
        pos_idx = r_s2_pos[POS_W-1 -: PIDX_W];
        pos_sat = (pos_idx > PIDX_W'(SAMPLES - 1));
        rd_addr = pos_sat ? ADDR_W'(SAMPLES - 1) : ADDR_W'(pos_idx);
        frac    = pos_sat ? {FRAC_W{1'b1}} : r_s2_pos[FRAC_W +: FRAC_W];
        do_write = en && r_s2_valid && (r_s2_mode == MODE_LOAD)
                   && ({1'b0, r_s2_eidx} < (EIDX_W+1)'(SAMPLES + 1));
        do_read  = en && r_s2_valid && (r_s2_mode == MODE_EVAL);
        diff    = {r_s3_b[V_W-1], r_s3_b} - {r_s3_a[V_W-1], r_s3_a};
        n_value = r_s4_a + r_s4_prod[FRAC_W +: V_W];
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else if (en) begin
            r_s1_valid <= i_pop_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid && (r_s2_mode == MODE_EVAL);
            r_s4_valid <= r_s3_valid;
            r_o_valid  <= r_s4_valid;
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_work   <= i_pop_work;
            r_s2_mode   <= r_s1_work.mode;
            r_s2_last   <= r_s1_work.last;
            r_s2_pos    <= POS_W'(r_s1_work.offset) * POS_W'(i_step);
            r_s2_eidx   <= r_s1_work.eidx;
            r_s2_evalue <= r_s1_work.evalue;
            r_s3_last   <= r_s2_last;
            r_s3_frac   <= frac;
            r_s4_last   <= r_s3_last;
            r_s4_a      <= r_s3_a;
            r_s4_prod   <= diff * signed'({1'b0, r_s3_frac});
            r_o_last    <= r_s4_last;
            r_o_value   <= n_value;
        end
    end

    // Sample table: one write port, two registered read ports, all in item order
    always_ff @(posedge i_clk) begin
        if (do_write) begin
            table_mem[ADDR_W'(r_s2_eidx)] <= r_s2_evalue;
        end
        if (do_read) begin
            r_s3_a <= table_mem[rd_addr];
            r_s3_b <= table_mem[rd_addr + 1'b1];
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tlast  = r_o_last;
    assign o_m_tdata  = {{(OUT_DATA_W - V_W){1'b0}}, r_o_value};

endmodule

/* sv/clamped_lerp_atan_table_unit.sv */
// Top level of the table-lookup arctangent unit: configuration registers and
// the front end, queue and back end. Depends on clat_pkg, clat_front,
// clat_queue and clat_back.
//
// Usage:
//   Input stream (s_axis): tuser is the mode (0 loads one table sample,
//   1 evaluates), tlast marks the last argument of a batch. tdata carries
//   entry_index, entry_value and sample_x. Load the table entries before any
//   evaluation reads them.
//   Output stream (m_axis): one item per evaluate item, none per load item,
//   in input order; tlast repeats the batch mark of its argument.
//   Configuration: write lower_limit, upper_limit and step_inverse through
//   i_cfg_wr_en / i_cfg_index / i_cfg_data while the unit is idle.
// Timing:
//   One item per cycle sustained while the output is not stalled. An item
//   passes the front register, queue write, queue pop register, multiply,
//   table read, interpolation multiply and output register, in that order.
// Reset and stall:
//   Synchronous reset empties the pipeline and queue and restores the
//   register defaults; table contents are kept.
//   A stalled output freezes the back pipeline; the 4-entry queue and the
//   front register keep accepting until full, then tready drops.
module clamped_lerp_atan_table_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // [8:0] entry_index, [26:9] entry_value, [50:27] sample_x, [55:51] zero
    input  logic [clat_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,
    // [0] mode
    input  logic                             i_s_axis_tuser,
    input  logic                             i_s_axis_tlast,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // [17:0] atan_value, [23:18] zero
    output logic [clat_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata,
    output logic                             o_m_axis_tlast,
    input  logic                             i_cfg_wr_en,
    input  logic [clat_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [clat_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import clat_pkg::*;

    logic signed [X_W-1:0] r_lower;
    logic signed [X_W-1:0] r_upper;
    logic [STEP_W-1:0]     r_step;

    logic                  push_valid;
    logic                  push_ready;
    t_work                 push_work;
    logic                  pop_valid;
    logic                  pop_ready;
    t_work                 pop_work;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lower <= LOWER_RESET;
            r_upper <= UPPER_RESET;
            r_step  <= STEP_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_LOWER_LIMIT:  r_lower <= signed'(i_cfg_data[X_W-1:0]);
                REG_UPPER_LIMIT:  r_upper <= signed'(i_cfg_data[X_W-1:0]);
                REG_STEP_INVERSE: r_step  <= i_cfg_data[STEP_W-1:0];
                default: begin
                    r_lower <= r_lower;
                end
            endcase
        end
    end

    clat_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_axis_tvalid),
        .o_s_tready   (o_s_axis_tready),
        .i_s_tdata    (i_s_axis_tdata),
        .i_s_tuser    (i_s_axis_tuser),
        .i_s_tlast    (i_s_axis_tlast),
        .i_lower      (r_lower),
        .i_upper      (r_upper),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_work  (push_work)
    );

    clat_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_work  (push_work),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_work   (pop_work)
    );

    clat_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (r_step),
        .i_pop_valid (pop_valid),
        .o_pop_ready (pop_ready),
        .i_pop_work  (pop_work),
        .o_m_tvalid  (o_m_axis_tvalid),
        .i_m_tready  (i_m_axis_tready),
        .o_m_tdata   (o_m_axis_tdata),
        .o_m_tlast   (o_m_axis_tlast)
    );

endmodule

/* sv/clat_checker.sv */
// Port-level checks for the table-lookup arctangent unit, bound to its top level.
// Depends on clat_pkg and clamped_lerp_atan_table_unit.
module clat_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_s_axis_tready,
    input logic                             o_m_axis_tvalid,
    input logic                             i_m_axis_tready,
    input logic [clat_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata,
    input logic                             o_m_axis_tlast
);
    import clat_pkg::*;

    // Reset empties the front end, so input is taken right after
    a_ready_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_s_axis_tready)
        else $error("input not ready after reset");

    // Pipeline is drained by reset, so no result appears straight after it
    a_no_result_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid ##1 !o_m_axis_tvalid)
        else $error("result appeared too soon after reset");

    // Result padding bits stay zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[OUT_DATA_W-1:V_W] == '0))
        else $error("result padding not zero");

    // Stalled result stays offered
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result dropped while stalled");

    // Stalled result keeps its payload
    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("result changed while stalled");

endmodule

bind clamped_lerp_atan_table_unit clat_checker u_clat_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
